// File: rtl/bmh_pkg.sv
// Package for the bit-mask histogram: item types, command codes,
// register indexes and configuration defaults. No dependencies.
`timescale 1ns / 1ps

package bmh_pkg;

  localparam int MAX_CHANNELS_DEF = 32;
  localparam int WORD_W = 32;
  localparam int COUNTER_W = 16;
  localparam int TOTAL_W = 32;
  localparam int LOW_BIT_W = 5;
  localparam int COUNT_W = 6;
  localparam int INDEX_W = 6;
  localparam int PADDR_W = 3;

  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic REG_LOW_BIT = 1'b0;
  localparam logic REG_CHANNEL_COUNT = 1'b1;

  localparam logic [LOW_BIT_W-1:0] LOW_BIT_RST = 5'd0;
  localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = 6'd32;

  typedef struct packed {
    logic [1:0] cmd;
    logic [WORD_W-1:0] event_value;
    logic event_valid;
    logic [INDEX_W-1:0] channel_index;
    logic [COUNTER_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic [COUNTER_W-1:0] read_data;
    logic range_error;
    logic [TOTAL_W-1:0] underflow_count;
    logic [TOTAL_W-1:0] overflow_count;
  } rsp_t;

endpackage

// File: rtl/bit_mask_histogram.sv
// Bit-mask histogram: request register, counter update logic, response register.
// Depends on bmh_pkg for item types, command codes and register indexes.
//
// Usage:
//   Request channel (req_valid, req_stall, req) carries one item: an event
//   word, a counter read or a counter write. Response channel (rsp_valid,
//   rsp_stall, rsp) returns one item per request with the read data, the
//   range error flag and the underflow and overflow totals after the request.
//   An item is registered in the request register on acceptance and its response
//   in the response register as it advances. The single counter-update pass
//   between the two registers sets the rate of one item taken every cycle while
//   rsp_stall does not hold the response register full. When it is held full,
//   the request register holds its item and req_stall rises until the response
//   moves. Reset clears all channel counters, both totals and both valid flags,
//   and sets low_bit to 0 and channel_count to 32. Configure over the APB port
//   (low_bit at 0x0, channel_count at 0x4) only while the block is idle.
`timescale 1ns / 1ps

module bit_mask_histogram #(
  parameter int MAX_CHANNELS = bmh_pkg::MAX_CHANNELS_DEF
) (
  input  logic clk,
  input  logic rst,

  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [bmh_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,

  input  logic req_valid,
  output logic req_stall,
  input  bmh_pkg::req_t req,

  output logic rsp_valid,
  input  logic rsp_stall,
  output bmh_pkg::rsp_t rsp
);

  localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [bmh_pkg::COUNT_W-1:0] MAX_N = bmh_pkg::COUNT_W'(MAX_CHANNELS);

  logic [bmh_pkg::LOW_BIT_W-1:0] low_bit;
  logic [bmh_pkg::COUNT_W-1:0] channel_count;

  logic pend_valid;
  bmh_pkg::req_t pend;
  logic advance;

  logic [bmh_pkg::COUNTER_W-1:0] counters [MAX_CHANNELS];
  logic [bmh_pkg::COUNTER_W-1:0] counters_next [MAX_CHANNELS];
  logic [bmh_pkg::TOTAL_W-1:0] underflow_total;
  logic [bmh_pkg::TOTAL_W-1:0] overflow_total;
  logic [bmh_pkg::TOTAL_W-1:0] underflow_total_next;
  logic [bmh_pkg::TOTAL_W-1:0] overflow_total_next;
  bmh_pkg::rsp_t rsp_next;

  logic [bmh_pkg::COUNT_W-1:0] active_n;
  logic [6:0] hi_pos;
  logic [bmh_pkg::WORD_W-1:0] mask_lo;
  logic [bmh_pkg::WORD_W-1:0] mask_hi;
  logic [bmh_pkg::WORD_W-1:0] window;
  logic [MAX_CHANNELS-1:0] inc;
  logic is_event;
  logic is_access;
  logic in_range;
  logic [CH_IDX_W-1:0] ch_idx;

  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [2:0] nib [8];
    logic [5:0] sum;
    for (int i = 0; i < 8; i++) begin
      nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
    end
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + 6'(nib[i]);
    end
    return sum;
  endfunction

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_bit <= bmh_pkg::LOW_BIT_RST;
      channel_count <= bmh_pkg::CHANNEL_COUNT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        bmh_pkg::REG_LOW_BIT: low_bit <= pwdata[bmh_pkg::LOW_BIT_W-1:0];
        bmh_pkg::REG_CHANNEL_COUNT: channel_count <= pwdata[bmh_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bmh_pkg::REG_LOW_BIT: prdata = 32'(low_bit);
      bmh_pkg::REG_CHANNEL_COUNT: prdata = 32'(channel_count);
      default: prdata = '0;
    endcase
  end

  assign advance = !rsp_valid || !rsp_stall;
  assign req_stall = pend_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (!req_stall) begin
      pend_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      pend <= req;
    end
  end

  always_comb begin
    active_n = (channel_count > MAX_N) ? MAX_N : channel_count;
    hi_pos = 7'(low_bit) + 7'(active_n);
    mask_lo = (32'd1 << low_bit) - 32'd1;
    mask_hi = (hi_pos >= 7'd32) ? '1 : ((32'd1 << hi_pos[4:0]) - 32'd1);
    window = pend.event_value >> low_bit;
    is_event = (pend.cmd == bmh_pkg::CMD_EVENT) && pend.event_valid;
    is_access = (pend.cmd == bmh_pkg::CMD_READ) || (pend.cmd == bmh_pkg::CMD_WRITE);
    in_range = (pend.channel_index < active_n) && (pend.channel_index < MAX_N);
    ch_idx = pend.channel_index[CH_IDX_W-1:0];

    for (int k = 0; k < MAX_CHANNELS; k++) begin
      inc[k] = window[k] && (bmh_pkg::COUNT_W'(k) < active_n);
      counters_next[k] = counters[k];
      if (is_event && inc[k]) begin
        counters_next[k] = counters[k] + 16'd1;
      end else if (pend.cmd == bmh_pkg::CMD_WRITE && in_range
                   && ch_idx == CH_IDX_W'(k)) begin
        counters_next[k] = pend.write_value;
      end
    end

    underflow_total_next = underflow_total;
    overflow_total_next = overflow_total;
    if (is_event) begin
      underflow_total_next = underflow_total
                             + 32'(popcount32(pend.event_value & mask_lo));
      overflow_total_next = overflow_total
                            + 32'(popcount32(pend.event_value & ~mask_hi));
    end

    rsp_next.read_data = '0;
    rsp_next.range_error = is_access && !in_range;
    if (pend.cmd == bmh_pkg::CMD_READ && in_range) begin
      rsp_next.read_data = counters[ch_idx];
    end
    rsp_next.underflow_count = underflow_total_next;
    rsp_next.overflow_count = overflow_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        counters[k] <= '0;
      end
      underflow_total <= '0;
      overflow_total <= '0;
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= pend_valid;
      if (pend_valid) begin
        for (int k = 0; k < MAX_CHANNELS; k++) begin
          counters[k] <= counters_next[k];
        end
        underflow_total <= underflow_total_next;
        overflow_total <= overflow_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pend_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule
